>>> rtl/core/ubxfr_pkg.sv
package ubxfr_pkg;

  localparam logic [7:0]  SYNC_FIRST      = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND     = 8'h62;
  localparam logic [15:0] MAX_LEN_RESET   = 16'd256;

  // header byte positions after the sync pair
  localparam logic [1:0]  HDR_CLASS       = 2'd0;
  localparam logic [1:0]  HDR_ID          = 2'd1;
  localparam logic [1:0]  HDR_LEN_LO      = 2'd2;
  localparam logic [1:0]  HDR_LEN_HI      = 2'd3;

  localparam int unsigned OUT_DATA_W      = 64;

  typedef struct packed {
    logic        length_rejected;
    logic [15:0] msg_length;
    logic [7:0]  msg_id;
    logic [7:0]  msg_class;
    logic        checksum_ok;
    logic        frame_done;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic        payload_valid;
  } result_t;

  // tdata layout from bit 0: payload_byte, payload_index, frame_done,
  // checksum_ok, msg_class, msg_id, msg_length, length_rejected, zero fill
  function automatic logic [OUT_DATA_W-1:0] pack_data(input result_t r);
    pack_data = {5'd0, r.length_rejected, r.msg_length, r.msg_id, r.msg_class,
                 r.checksum_ok, r.frame_done, r.payload_index, r.payload_byte};
  endfunction

endpackage

>>> rtl/core/ubx_frame_receiver_unit.sv
// Frame receiver for the UBX serial protocol. One received byte enters per word on the
// slave stream, and exactly one result word leaves per input byte, registered, on
// the master stream. The block hunts for the sync pair B5 62, captures class, id and the
// little-endian length, streams payload bytes with their index and checks the two
// Fletcher-8 checksum bytes, flagging frame_done and checksum_ok on the last one.
// Throughput is one byte per clock while skid_valid is low; the state update and both
// 8-bit sum adds sit between the input and the result register. A two-deep output
// (result plus skid register) lets a byte be taken while a result waits downstream.
// Lengths at or above max_len (256 after reset) drop the frame and restart the hunt.
// Write max_len via cfg_wr_en and cfg_wr_data only while idle; not enforced here.
module ubx_frame_receiver_unit
  import ubxfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // rx_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // payload_byte, payload_index, frame_done, checksum_ok, msg_class, msg_id,
  // msg_length, length_rejected
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser    // payload_valid
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CHECK   = 2'd3
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] max_len;
  logic [15:0] byte_counter, byte_counter_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  frame_class, frame_class_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [15:0] frame_length, frame_length_next;
  logic        first_check_ok, first_check_ok_next;

  result_t     res;
  result_t     out_reg;
  result_t     skid;
  logic        skid_valid;
  logic        in_accept;
  logic        out_pop;
  logic [7:0]  b;
  logic [7:0]  acc_a;
  logic [15:0] cnt_inc;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !skid_valid;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_pop       = !m_axis_tvalid || m_axis_tready;
  assign acc_a         = sum_a + b;
  assign cnt_inc       = byte_counter + 16'd1;

  always_comb begin
    phase_next          = phase;
    byte_counter_next   = byte_counter;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    frame_class_next    = frame_class;
    frame_id_next       = frame_id;
    frame_length_next   = frame_length;
    first_check_ok_next = first_check_ok;
    res                 = '0;

    unique case (phase)
      PH_HUNT: begin
        if (byte_counter[0] == 1'b0 && b == SYNC_FIRST) begin
          byte_counter_next = 16'd1;
        end else if (byte_counter[0] == 1'b1 && b == SYNC_SECOND) begin
          byte_counter_next = '0;
          phase_next        = PH_HEADER;
          sum_a_next        = '0;
          sum_b_next        = '0;
          frame_class_next  = '0;
          frame_id_next     = '0;
          frame_length_next = '0;
        end else begin
          // mismatch restarts the hunt; this byte is not retried as B5
          byte_counter_next = '0;
        end
      end
      PH_HEADER: begin
        sum_a_next        = acc_a;
        sum_b_next        = sum_b + acc_a;
        byte_counter_next = {14'd0, byte_counter[1:0] + 2'd1};
        unique case (byte_counter[1:0])
          HDR_CLASS:  frame_class_next = b;
          HDR_ID:     frame_id_next = b;
          HDR_LEN_LO: frame_length_next = {frame_length[15:8], b};
          HDR_LEN_HI: begin
            frame_length_next = {b, frame_length[7:0]};
            byte_counter_next = '0;
            if ({b, frame_length[7:0]} >= max_len) begin
              phase_next          = PH_HUNT;
              res.length_rejected = 1'b1;
            end else if ({b, frame_length[7:0]} == 16'd0) begin
              phase_next = PH_CHECK;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
          default: ;
        endcase
      end
      PH_PAYLOAD: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = b;
        res.payload_index = byte_counter;
        sum_a_next        = acc_a;
        sum_b_next        = sum_b + acc_a;
        if (cnt_inc == frame_length) begin
          byte_counter_next = '0;
          phase_next        = PH_CHECK;
        end else begin
          byte_counter_next = cnt_inc;
        end
      end
      PH_CHECK: begin
        if (byte_counter == 16'd0) begin
          first_check_ok_next = (b == sum_a);
          byte_counter_next   = 16'd1;
        end else begin
          res.frame_done    = 1'b1;
          res.checksum_ok   = first_check_ok && (b == sum_b);
          byte_counter_next = '0;
          phase_next        = PH_HUNT;
        end
      end
      default: ;
    endcase

    res.msg_class  = frame_class_next;
    res.msg_id     = frame_id_next;
    res.msg_length = frame_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len        <= MAX_LEN_RESET;
      phase          <= PH_HUNT;
      byte_counter   <= '0;
      sum_a          <= '0;
      sum_b          <= '0;
      frame_class    <= '0;
      frame_id       <= '0;
      frame_length   <= '0;
      first_check_ok <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
      if (in_accept) begin
        phase          <= phase_next;
        byte_counter   <= byte_counter_next;
        sum_a          <= sum_a_next;
        sum_b          <= sum_b_next;
        frame_class    <= frame_class_next;
        frame_id       <= frame_id_next;
        frame_length   <= frame_length_next;
        first_check_ok <= first_check_ok_next;
      end
      if (out_pop) begin
        if (skid_valid) begin
          out_reg    <= skid;
          skid_valid <= 1'b0;
          m_axis_tvalid <= 1'b1;
        end else begin
          out_reg       <= res;
          m_axis_tvalid <= in_accept;
        end
      end else if (in_accept) begin
        // result register is stalled: park the word
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_axis_tdata = pack_data(out_reg);
  assign m_axis_tuser = out_reg.payload_valid;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid word held with empty result register");

  a_done_not_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(out_reg.payload_valid && out_reg.frame_done))
    else $error("payload and frame end flagged on one word");

  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_reg.checksum_ok) |-> out_reg.frame_done)
    else $error("checksum_ok without frame_done");

  a_reject_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (in_accept && res.length_rejected) |=> (phase == PH_HUNT && byte_counter == 16'd0))
    else $error("rejected length did not restart the hunt");

endmodule
